### src/assert_macros.svh
// Assertion macros shared by the voice activity detector RTL.
// Checks compile only in simulation; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### src/evad_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the voice activity detector.
// No dependencies; every other RTL file refers to it by scoped names.
package evad_pkg;

  // Frame length limit and the widths that follow from it.
  localparam int MAX_FRAME = 1024;
  localparam int TALLY_W = $clog2(MAX_FRAME + 1);
  localparam int SQUARE_W = 31;
  localparam int ACC_W = SQUARE_W - 1 + TALLY_W;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  // Mean square and its normalization.
  localparam int MEAN_W = 31;
  localparam int SH_W = 5;

  // Fractional log2 table.
  localparam int LOG_TABLE_BITS = 6;
  localparam int LOG_ENTRIES = 1 << LOG_TABLE_BITS;
  localparam int FRAC_W = 16;

  // Levels in 1/256 dB.
  localparam int LEVEL_W = 16;
  localparam int LEVEL_MIN = -30720;
  localparam int LEVEL_MAG_MAX = 30720;
  localparam int LOG_SCALE_Q16 = 197283;
  localparam logic signed [LEVEL_W-1:0] NOISE_RESET = -16'sd12800;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 18;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  // Configuration registers.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MARGIN_W = 14;
  localparam int HOLD_W = 8;
  localparam int RATE_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_MARGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RATE = 2'd2;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 14'd3840;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd5;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd3277;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic [ACC_W-1:0] dividend;
    logic [TALLY_W-1:0] divisor;
  } div_req_t;

  typedef logic [LOG_ENTRIES-1:0][FRAC_W-1:0] log_table_t;

  // log2(1 + i/2^B) in Q0.16 by repeated squaring of a Q1.30 mantissa,
  // each square truncated. Evaluated once while elaborating.
  function automatic log_table_t build_log_table();
    log_table_t t;
    logic [63:0] m;
    logic [FRAC_W-1:0] r;
    t = '0;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int k = FRAC_W - 1; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r[k] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

  // Limit a level to the range -120 dB .. 0 dB.
  function automatic logic signed [LEVEL_W-1:0] clamp_level(input logic signed [LEVEL_W:0] v);
    logic signed [LEVEL_W-1:0] r;
    if (v < (LEVEL_W+1)'(LEVEL_MIN)) begin
      r = LEVEL_W'(LEVEL_MIN);
    end else if (v > (LEVEL_W+1)'(0)) begin
      r = '0;
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/evad_mul.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on evad_pkg for the operand and product widths.
module evad_mul (
  input  logic                          clk,
  input  logic [evad_pkg::MUL_A_W-1:0]  op_a,
  input  logic [evad_pkg::MUL_B_W-1:0]  op_b,
  output logic [evad_pkg::PROD_W-1:0]   prod
);

  // The product is registered and lands in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod <= evad_pkg::PROD_W'(op_a) * evad_pkg::PROD_W'(op_b);
  end

endmodule

### src/evad_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the frame mean square.
// Depends on evad_pkg for widths and the request struct.
module evad_div (
  input  logic                        clk,
  input  logic                        rst,
  input  evad_pkg::div_req_t          req,
  output logic                        busy,
  output logic [evad_pkg::ACC_W-1:0]  quotient
);

  logic [evad_pkg::DIV_CNT_W-1:0] cnt;
  logic [evad_pkg::TALLY_W-1:0] rem;
  logic [evad_pkg::TALLY_W-1:0] divisor;
  logic [evad_pkg::ACC_W-1:0] dq;
  logic [evad_pkg::TALLY_W:0] shifted;
  logic fits;
  logic [evad_pkg::TALLY_W-1:0] rem_next;

  // One step: bring down the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem, dq[evad_pkg::ACC_W-1]};
    fits = shifted >= {1'b0, divisor};
    if (fits) begin
      rem_next = evad_pkg::TALLY_W'(shifted - {1'b0, divisor});
    end else begin
      rem_next = evad_pkg::TALLY_W'(shifted);
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= evad_pkg::DIV_CNT_W'(evad_pkg::ACC_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == evad_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      divisor <= req.divisor;
      dq <= req.dividend;
    end else if (busy) begin
      rem <= rem_next;
      dq <= {dq[evad_pkg::ACC_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

### src/energy_voice_activity_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the energy voice activity detector: sequencer and datapath.
// Depends on evad_pkg, evad_mul, evad_div and assert_macros.svh.
//
// Each sample is squared in the shared multiplier and then added into the
// frame energy. The sample marked frame_end then runs the frame computation
// before the next sample is taken; its length is set by the divider (one
// quotient bit per cycle over the 41-bit energy) and by the leading-one
// search, which shifts the mean one bit per cycle, with more shifts for
// quieter frames. The shared multiplier also does the dB scaling and the
// noise floor step. A finished result waits in an output register, so the
// next frame's samples are taken meanwhile; the block only holds at the end
// of a frame if the previous result is still stalled.
// Levels are in 1/256 dB; a silent frame reads -120 dB.
`include "assert_macros.svh"

module energy_voice_activity_detector_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration writes.
  input  logic                                   cfg_write,
  input  logic [evad_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Sample channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [15:0]                     sample,
  input  logic                                   frame_end,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   voice_active,
  output logic signed [evad_pkg::LEVEL_W-1:0]    frame_level,
  output logic signed [evad_pkg::LEVEL_W-1:0]    floor_level
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_RND,
    ST_FLOOR_MUL,
    ST_FLOOR_UPD,
    ST_DECIDE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [evad_pkg::MARGIN_W-1:0] speech_margin;
  logic [evad_pkg::HOLD_W-1:0] hold_frames;
  logic [evad_pkg::RATE_W-1:0] floor_rate;

  // Frame state.
  logic [evad_pkg::ACC_W-1:0] energy_acc;
  logic [evad_pkg::TALLY_W-1:0] sample_tally;
  logic signed [evad_pkg::LEVEL_W-1:0] noise_level;
  logic [evad_pkg::HOLD_W-1:0] hold_left;
  logic last;

  // Frame computation registers.
  logic [evad_pkg::MEAN_W-1:0] mean;
  logic [evad_pkg::SH_W-1:0] sh;
  logic signed [evad_pkg::LEVEL_W-1:0] level;
  logic floor_move;
  logic d_neg;

  // Shared units.
  logic [evad_pkg::MUL_A_W-1:0] op_a;
  logic [evad_pkg::MUL_B_W-1:0] op_b;
  logic [evad_pkg::PROD_W-1:0] prod;
  evad_pkg::div_req_t div_req;
  logic div_busy;
  logic [evad_pkg::ACC_W-1:0] quotient;

  // Combinational datapath values.
  logic [15:0] sample_mag;
  logic accept;
  logic [evad_pkg::LOG_TABLE_BITS-1:0] idx;
  logic [evad_pkg::FRAC_W-1:0] frac;
  logic [evad_pkg::MUL_A_W-1:0] log_mag;
  logic [evad_pkg::PROD_W:0] lvl_rnd;
  logic [evad_pkg::LEVEL_W-1:0] lvl_mag;
  logic signed [evad_pkg::LEVEL_W:0] floor_thr;
  logic signed [evad_pkg::LEVEL_W:0] level_ext;
  logic signed [evad_pkg::LEVEL_W:0] diff;
  logic [evad_pkg::LEVEL_W-1:0] diff_mag;
  logic [evad_pkg::PROD_W-1:0] step_rnd;
  logic [evad_pkg::LEVEL_W-1:0] step_mag;
  logic signed [evad_pkg::LEVEL_W:0] floor_sum;
  logic signed [evad_pkg::LEVEL_W-1:0] floor_new;
  logic speech;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && (state == ST_IDLE);

  // Magnitude of the sample; -32768 maps to 32768, which fits in 16 bits.
  assign sample_mag = (sample ^ {16{sample[15]}}) + {15'd0, sample[15]};

  // Fraction bits below the leading one, once the mean is normalized.
  assign idx = mean[evad_pkg::MEAN_W-2 -: evad_pkg::LOG_TABLE_BITS];
  assign frac = evad_pkg::LOG_TABLE[idx];
  assign log_mag = {sh, evad_pkg::FRAC_W'(0)} - evad_pkg::MUL_A_W'(frac);

  // Round the scaled log and limit it to the level range.
  always_comb begin
    lvl_rnd = {1'b0, prod} + (evad_pkg::PROD_W+1)'(1 << 23);
    lvl_mag = lvl_rnd[24 +: evad_pkg::LEVEL_W];
    if (lvl_mag > evad_pkg::LEVEL_W'(evad_pkg::LEVEL_MAG_MAX)) begin
      lvl_mag = evad_pkg::LEVEL_W'(evad_pkg::LEVEL_MAG_MAX);
    end
  end

  // Noise floor comparison and step.
  always_comb begin
    floor_thr = {noise_level[evad_pkg::LEVEL_W-1], noise_level}
                + $signed({3'b000, speech_margin});
    level_ext = {level[evad_pkg::LEVEL_W-1], level};
    diff = level_ext - {noise_level[evad_pkg::LEVEL_W-1], noise_level};
    diff_mag = diff[evad_pkg::LEVEL_W] ? evad_pkg::LEVEL_W'(-diff)
                                       : diff[evad_pkg::LEVEL_W-1:0];
    step_rnd = prod + evad_pkg::PROD_W'(32768);
    step_mag = step_rnd[16 +: evad_pkg::LEVEL_W];
    if (d_neg) begin
      floor_sum = {noise_level[evad_pkg::LEVEL_W-1], noise_level} - $signed({1'b0, step_mag});
    end else begin
      floor_sum = {noise_level[evad_pkg::LEVEL_W-1], noise_level} + $signed({1'b0, step_mag});
    end
    floor_new = evad_pkg::clamp_level(floor_sum);
    speech = level_ext > floor_thr;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      ST_IDLE: begin
        op_a = evad_pkg::MUL_A_W'(sample_mag);
        op_b = evad_pkg::MUL_B_W'(sample_mag);
      end
      ST_LOG_MUL: begin
        op_a = log_mag;
        op_b = evad_pkg::MUL_B_W'(evad_pkg::LOG_SCALE_Q16);
      end
      ST_FLOOR_MUL: begin
        op_a = evad_pkg::MUL_A_W'(diff_mag);
        op_b = evad_pkg::MUL_B_W'(floor_rate);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = (state == ST_DIV_GO);
    div_req.dividend = energy_acc;
    div_req.divisor = sample_tally;
  end

  evad_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  evad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      speech_margin <= evad_pkg::MARGIN_RESET;
      hold_frames <= evad_pkg::HOLD_RESET;
      floor_rate <= evad_pkg::RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        evad_pkg::REG_SPEECH_MARGIN: speech_margin <= cfg_data[evad_pkg::MARGIN_W-1:0];
        evad_pkg::REG_HOLD_FRAMES:   hold_frames <= cfg_data[evad_pkg::HOLD_W-1:0];
        evad_pkg::REG_FLOOR_RATE:    floor_rate <= cfg_data[evad_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the frame state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      energy_acc <= '0;
      sample_tally <= '0;
      noise_level <= evad_pkg::NOISE_RESET;
      hold_left <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one replaces it.
      if (out_valid && !out_stall && state != ST_DECIDE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last <= frame_end;
            state <= ST_ACC;
          end
        end
        // Samples past the frame limit are dropped from the sums.
        ST_ACC: begin
          if (sample_tally < evad_pkg::TALLY_W'(evad_pkg::MAX_FRAME)) begin
            energy_acc <= energy_acc + evad_pkg::ACC_W'(prod);
            sample_tally <= sample_tally + 1'b1;
          end
          state <= last ? ST_DIV_GO : ST_IDLE;
        end
        // The divider latches the sums here, so the next frame starts clean.
        ST_DIV_GO: begin
          energy_acc <= '0;
          sample_tally <= '0;
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (!div_busy) begin
            mean <= quotient[evad_pkg::MEAN_W-1:0];
            sh <= '0;
            state <= ST_NORM;
          end
        end
        // Shift the mean up until its leading one sits at the top bit.
        ST_NORM: begin
          if (mean == '0) begin
            level <= evad_pkg::LEVEL_W'(evad_pkg::LEVEL_MIN);
            state <= ST_FLOOR_MUL;
          end else if (mean[evad_pkg::MEAN_W-1]) begin
            if (sh == '0) begin
              level <= '0;
              state <= ST_FLOOR_MUL;
            end else begin
              state <= ST_LOG_MUL;
            end
          end else begin
            mean <= {mean[evad_pkg::MEAN_W-2:0], 1'b0};
            sh <= sh + 1'b1;
          end
        end
        ST_LOG_MUL: begin
          state <= ST_LOG_RND;
        end
        ST_LOG_RND: begin
          level <= evad_pkg::LEVEL_W'(0) - lvl_mag;
          state <= ST_FLOOR_MUL;
        end
        ST_FLOOR_MUL: begin
          floor_move <= level_ext < floor_thr;
          d_neg <= diff[evad_pkg::LEVEL_W];
          state <= ST_FLOOR_UPD;
        end
        ST_FLOOR_UPD: begin
          if (floor_move) begin
            noise_level <= floor_new;
          end
          state <= ST_DECIDE;
        end
        // Speech and hangover decision, then hand the result over.
        ST_DECIDE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            frame_level <= level;
            floor_level <= noise_level;
            if (speech) begin
              hold_left <= hold_frames;
              voice_active <= 1'b1;
            end else if (hold_left != '0) begin
              hold_left <= hold_left - 1'b1;
              voice_active <= 1'b1;
            end else begin
              voice_active <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_tally_limit, clk, rst, sample_tally > evad_pkg::TALLY_W'(evad_pkg::MAX_FRAME), "frame tally ran past the frame limit")
  `ASSERT_NEVER(a_floor_range, clk, rst, noise_level > 16'sd0 || noise_level < 16'(evad_pkg::LEVEL_MIN), "noise floor left the level range")
  `ASSERT_PROP(a_out_level, clk, rst, out_valid |-> (frame_level <= 16'sd0 && frame_level >= 16'(evad_pkg::LEVEL_MIN)), "result level out of range")
  `ASSERT_PROP(a_idle_div, clk, rst, (state == ST_IDLE) |-> !div_busy, "divider still running while taking samples")
  `ASSERT_PROP(a_result_src, clk, rst, $rose(out_valid) |-> $past(state == ST_DECIDE), "result loaded outside the decision step")

endmodule
